// ===== hdl/lfsa_pkg.sv =====
// Shared constants, action codes and slot word type for the lowest free slot allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package lfsa_pkg;

  localparam int ACTION_W  = 2;
  localparam int SLOT_W    = 10;
  localparam int VALUE_W   = 31;
  localparam int SC_W      = 11;
  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = 5;
  localparam int WORD_IDX_W = SLOT_W - BIT_IDX_W;

  localparam int SLOT_COUNT_MAX_DEF = 1024;
  localparam int SC_RESET           = 1024;

  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd3;

  // One stored word covers 32 slots: a free bit and a nonzero bit per slot.
  typedef struct packed {
    logic [WORD_BITS-1:0] nonzero;
    logic [WORD_BITS-1:0] free;
  } slot_word_t;

endpackage

`default_nettype wire

// ===== hdl/lfsa_ffs.sv =====
// Shared find-first-set unit: lowest set bit of one 32-bit word.
// Depends on lfsa_pkg for the word width.
`default_nettype none

module lfsa_ffs (
  input  wire logic [lfsa_pkg::WORD_BITS-1:0] vec_i,
  output logic      [lfsa_pkg::BIT_IDX_W-1:0] idx_o,
  output logic                                any_o
);

  always_comb begin
    idx_o = '0;
    // scan from the top so the lowest set bit wins
    for (int i = lfsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = lfsa_pkg::BIT_IDX_W'(i);
      end
    end
    any_o = |vec_i;
  end

endmodule

`default_nettype wire

// ===== hdl/lfsa_slot_mem.sv =====
// Slot word memory: one read and one write port, registered read data.
// Per-word valid bits make unwritten words read as zero after reset. Depends on lfsa_pkg.
`default_nettype none

module lfsa_slot_mem #(
  parameter int Depth = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output lfsa_pkg::slot_word_t             rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  wire lfsa_pkg::slot_word_t        wr_data_i
);

  lfsa_pkg::slot_word_t mem [Depth];
  lfsa_pkg::slot_word_t rd_word_q;
  logic [Depth-1:0]     valid_q;
  logic                 rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_word_q : '0;

endmodule

`default_nettype wire

// ===== hdl/lowest_free_slot_allocator_unit.sv =====
// Lowest free slot allocator: each item passes accept, lookup and update, one item at a time,
// set by the single memory port and the shared find-first unit used twice per item.
// A query result is written to an output register at the end of update (update holds
// until that register can take it); it waits there while the next item is taken. rst_ni clears all
// slots to not free and sets slot_count to 1024 (or SlotCountMax if smaller).
// Depends on lfsa_pkg, lfsa_ffs, lfsa_slot_mem.
`default_nettype none

module lowest_free_slot_allocator_unit #(
  parameter int SlotCountMax = lfsa_pkg::SLOT_COUNT_MAX_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lfsa_pkg::SC_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [lfsa_pkg::ACTION_W-1:0]  action_i,
  input  wire logic [lfsa_pkg::SLOT_W-1:0]    slot_i,
  input  wire logic [lfsa_pkg::VALUE_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                found_o,
  output logic [lfsa_pkg::SLOT_W-1:0]         free_slot_o
);

  localparam int WordCount  = (SlotCountMax + lfsa_pkg::WORD_BITS - 1) / lfsa_pkg::WORD_BITS;
  localparam int WordLimit  = 2 ** lfsa_pkg::WORD_IDX_W;
  localparam int MemDepth   = (WordCount < WordLimit) ? WordCount : WordLimit;
  localparam int WordAw     = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int ScResetInt = (lfsa_pkg::SC_RESET > SlotCountMax) ? SlotCountMax
                                                                 : lfsa_pkg::SC_RESET;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_q, state_d;

  logic [lfsa_pkg::SC_W-1:0]     sc_q, sc_d;
  logic [lfsa_pkg::ACTION_W-1:0] act_q;
  logic [lfsa_pkg::SLOT_W-1:0]   slot_q;
  logic                          val_nz_q;
  logic [WordAw-1:0]             word_q, word_d;
  logic                          any_q, any_d;
  logic [MemDepth-1:0]           summary_q, summary_d;

  logic                          out_valid_q, out_valid_d;
  logic                          found_q;
  logic [lfsa_pkg::SLOT_W-1:0]   free_slot_q;

  logic [lfsa_pkg::WORD_BITS-1:0] ffs_vec;
  logic [lfsa_pkg::BIT_IDX_W-1:0] ffs_idx;
  logic                           ffs_any;

  logic                  mem_re, mem_we;
  logic [WordAw-1:0]     mem_raddr;
  lfsa_pkg::slot_word_t  rd_word, wr_word;

  logic                           searching;
  logic [lfsa_pkg::BIT_IDX_W-1:0] bit_idx;
  logic [lfsa_pkg::WORD_BITS-1:0] bmask;
  logic [lfsa_pkg::SLOT_W-1:0]    found_slot, slot_sel;
  logic                           in_range, can_push, push, res_found;

  logic in_xfer;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign searching = (act_q == lfsa_pkg::ACT_ALLOC) || (act_q == lfsa_pkg::ACT_QUERY);

  // Shared find-first: summary bits during lookup, the read word's free bits during update.
  assign ffs_vec = (state_q == ST_LOOKUP) ? lfsa_pkg::WORD_BITS'(summary_q) : rd_word.free;

  lfsa_ffs u_ffs (
    .vec_i (ffs_vec),
    .idx_o (ffs_idx),
    .any_o (ffs_any)
  );

  assign mem_re    = (state_q == ST_LOOKUP);
  assign mem_raddr = searching ? ffs_idx[WordAw-1:0] : slot_q[lfsa_pkg::BIT_IDX_W +: WordAw];

  lfsa_slot_mem #(
    .Depth (MemDepth)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (rd_word),
    .wr_en_i   (mem_we),
    .wr_addr_i (word_q),
    .wr_data_i (wr_word)
  );

  assign bit_idx    = searching ? ffs_idx : slot_q[lfsa_pkg::BIT_IDX_W-1:0];
  assign bmask      = lfsa_pkg::WORD_BITS'(1) << bit_idx;
  assign found_slot = {lfsa_pkg::WORD_IDX_W'(word_q), bit_idx};
  assign slot_sel   = searching ? found_slot : slot_q;
  assign in_range   = ({1'b0, slot_sel} < sc_q);
  assign can_push   = !out_valid_q || !out_stall_i;
  assign res_found  = any_q && in_range;

  always_comb begin
    mem_we  = 1'b0;
    wr_word = rd_word;
    push    = 1'b0;
    if (state_q == ST_UPDATE) begin
      case (act_q)
        lfsa_pkg::ACT_LOAD: begin
          mem_we          = in_range;
          wr_word.free    = (rd_word.free & ~bmask) | (val_nz_q ? '0 : bmask);
          wr_word.nonzero = (rd_word.nonzero & ~bmask) | (val_nz_q ? bmask : '0);
        end
        lfsa_pkg::ACT_ALLOC: begin
          mem_we          = res_found;
          wr_word.free    = rd_word.free & ~bmask;
          wr_word.nonzero = (rd_word.nonzero & ~bmask) | (val_nz_q ? bmask : '0);
        end
        lfsa_pkg::ACT_FREE: begin
          mem_we          = in_range && rd_word.nonzero[bit_idx];
          wr_word.free    = rd_word.free | bmask;
          wr_word.nonzero = rd_word.nonzero & ~bmask;
        end
        lfsa_pkg::ACT_QUERY: begin
          push = can_push;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    any_d     = any_q;
    summary_d = summary_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        word_d  = mem_raddr;
        any_d   = ffs_any;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (mem_we) begin
          summary_d[word_q] = |wr_word.free;
        end
        // hold until the output register can take the query result
        if (act_q != lfsa_pkg::ACT_QUERY || can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sc_d = sc_q;
    if (cfg_we_i) begin
      if (int'(cfg_wdata_i) > SlotCountMax) begin
        sc_d = lfsa_pkg::SC_W'(SlotCountMax);
      end else begin
        sc_d = cfg_wdata_i;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sc_q        <= lfsa_pkg::SC_W'(ScResetInt);
      summary_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sc_q        <= sc_d;
      summary_q   <= summary_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q    <= action_i;
      slot_q   <= slot_i;
      val_nz_q <= |value_i;
    end
    word_q <= word_d;
    any_q  <= any_d;
    if (push) begin
      found_q     <= res_found;
      free_slot_q <= res_found ? found_slot : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign free_slot_o = free_slot_q;

`ifndef SYNTH
  a_summary_tracks_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> summary_q[$past(word_q)] == ($past(wr_word.free) != '0))
    else $error("summary bit does not match written word");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || !out_stall_i))
    else $error("query result overwrites a pending transfer");

  a_found_needs_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && res_found) |-> (summary_q != '0))
    else $error("slot reported free while summary is empty");

  a_write_only_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (state_q == ST_IDLE))
    else $error("slot word written outside the last step of an item");
`endif

endmodule

`default_nettype wire
